FILE: rtl/dbpi_pkg.sv
// Shared constants and types for the dead-band PI light controller.
package dbpi_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int DUTY_W      = 10;
	localparam int ERR_W       = 13;
	localparam int INTEG_W     = 16;
	localparam int PROP_SHIFT  = 3;
	localparam int INTEG_SHIFT = 5;

	localparam logic [ERR_W-1:0] DEF_BAND_UP   = 13'd1200;
	localparam logic [ERR_W-1:0] DEF_BAND_DOWN = 13'd1000;
	localparam logic [ERR_W-1:0] BAND_HALF     = 13'd100;
	localparam logic [ERR_W-1:0] TARGET_MIN    = 13'd200;
	localparam logic [ERR_W-1:0] TARGET_MAX    = 13'd4000;

	localparam logic signed [INTEG_W:0]   INTEG_LIMIT = 17'(999 << INTEG_SHIFT);
	localparam logic signed [INTEG_W-1:0] DUTY_MAX    = 16'sd999;

	typedef enum logic [0:0] {
		REG_TARGET_LEVEL = 1'b0,
		REG_LOOP_ENABLE  = 1'b1
	} reg_index_t;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic step;
		logic clear;
	} integ_ctl_t;

endpackage

FILE: rtl/deadband_pi_light_controller.sv
// Top level of the dead-band PI light controller.
//
// Usage:
//   Sensor samples arrive on the sample channel (sample_valid/sample_ready);
//   each word yields exactly one result word on the result channel
//   (result_valid/result_ready) carrying duty and active.
//   The configuration port writes target_level (index 0) or loop_enable
//   (index 1) whenever cfg_we is high; write only while idle.
//   A write that raises loop_enable clears the integrator.
//   Throughput: one sample per cycle unless the receiver stalls; an input
//   register and a result register sit around a single add-clamp-saturate
//   pass through the integrator, which carries state from one sample to
//   the next, and a sample moves from the input to the result register.
//   When the receiver stalls, the result register holds, the input
//   register fills, and sample_ready drops until result_ready returns.
//   While loop_enable is 0 results carry duty 0 and active 0 and the
//   integrator holds.
//   Reset clears both registers' valid flags, the integrator, the
//   enable flag and target_level.
module deadband_pi_light_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [dbpi_pkg::SAMPLE_W-1:0] cfg_data,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic [dbpi_pkg::SAMPLE_W-1:0] sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [dbpi_pkg::DUTY_W-1:0] duty,
	output logic                        active
);

	logic [dbpi_pkg::SAMPLE_W-1:0] target_q;
	logic                          enable_q;
	logic                          valid_s1;
	logic [dbpi_pkg::SAMPLE_W-1:0] sample_s1;
	logic                          valid_s2;
	logic [dbpi_pkg::DUTY_W-1:0]   duty_s2;
	logic                          active_s2;
	logic                          out_free;
	logic                          step;
	dbpi_pkg::err_t                err;
	dbpi_pkg::integ_ctl_t          ctl;
	logic [dbpi_pkg::DUTY_W-1:0]   duty_c;
	logic                          wr_target;
	logic                          wr_enable;

	assign wr_target = cfg_we && (cfg_index == dbpi_pkg::REG_TARGET_LEVEL);
	assign wr_enable = cfg_we && (cfg_index == dbpi_pkg::REG_LOOP_ENABLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			enable_q <= 1'b0;
		end else begin
			if (wr_target)
				target_q <= cfg_data;
			if (wr_enable)
				enable_q <= cfg_data[0];
		end
	end

	assign out_free     = !valid_s2 || result_ready;
	assign sample_ready = !valid_s1 || out_free;
	assign step         = valid_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid)
			sample_s1 <= sample;
	end

	dbpi_error u_error (
		.target_level (target_q),
		.sample       (sample_s1),
		.err          (err)
	);

	assign ctl.step  = step && enable_q;
	assign ctl.clear = wr_enable && cfg_data[0] && !enable_q;

	dbpi_integ u_integ (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.err    (err),
		.duty   (duty_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			duty_s2   <= enable_q ? duty_c : '0;
			active_s2 <= enable_q;
		end
	end

	assign result_valid = valid_s2;
	assign duty         = duty_s2;
	assign active       = active_s2;

endmodule

FILE: rtl/dbpi_error.sv
// Band selection from the target and dead-band error of one sample.
module dbpi_error (
	input  logic [dbpi_pkg::SAMPLE_W-1:0] target_level,
	input  logic [dbpi_pkg::SAMPLE_W-1:0] sample,
	output dbpi_pkg::err_t                err
);

	logic [dbpi_pkg::ERR_W-1:0] t;
	logic [dbpi_pkg::ERR_W-1:0] s;
	logic [dbpi_pkg::ERR_W-1:0] up;
	logic [dbpi_pkg::ERR_W-1:0] down;
	logic                       in_range;

	assign t = dbpi_pkg::ERR_W'(target_level);
	assign s = dbpi_pkg::ERR_W'(sample);
	assign in_range = (t >= dbpi_pkg::TARGET_MIN) && (t <= dbpi_pkg::TARGET_MAX);

	always_comb begin
		if (in_range) begin
			up = t + dbpi_pkg::BAND_HALF;
			if (t > dbpi_pkg::BAND_HALF + dbpi_pkg::TARGET_MIN)
				down = t - dbpi_pkg::BAND_HALF;
			else
				down = dbpi_pkg::TARGET_MIN;
		end else begin
			up   = dbpi_pkg::DEF_BAND_UP;
			down = dbpi_pkg::DEF_BAND_DOWN;
		end
	end

	always_comb begin
		priority if (s > up)
			err = signed'(s - up);
		else if (s < down)
			err = signed'(s - down);
		else
			err = '0;
	end

endmodule

FILE: rtl/dbpi_integ.sv
// Clamped integrator and saturated duty computation.
module dbpi_integ (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dbpi_pkg::integ_ctl_t        ctl,
	input  dbpi_pkg::err_t              err,
	output logic [dbpi_pkg::DUTY_W-1:0] duty
);

	logic signed [dbpi_pkg::INTEG_W-1:0] integ_q;
	logic signed [dbpi_pkg::INTEG_W:0]   sum;
	logic signed [dbpi_pkg::INTEG_W-1:0] integ_next;
	logic signed [dbpi_pkg::INTEG_W-1:0] p_term;
	logic signed [dbpi_pkg::INTEG_W-1:0] i_term;
	logic signed [dbpi_pkg::INTEG_W-1:0] o;

	assign sum = (dbpi_pkg::INTEG_W+1)'(integ_q) + (dbpi_pkg::INTEG_W+1)'(err);

	always_comb begin
		priority if (sum > dbpi_pkg::INTEG_LIMIT)
			integ_next = dbpi_pkg::INTEG_W'(dbpi_pkg::INTEG_LIMIT);
		else if (sum < -dbpi_pkg::INTEG_LIMIT)
			integ_next = dbpi_pkg::INTEG_W'(-dbpi_pkg::INTEG_LIMIT);
		else
			integ_next = dbpi_pkg::INTEG_W'(sum);
	end

	assign p_term = dbpi_pkg::INTEG_W'(err >>> dbpi_pkg::PROP_SHIFT);
	assign i_term = integ_next >>> dbpi_pkg::INTEG_SHIFT;
	assign o      = p_term + i_term;

	always_comb begin
		priority if (o < 0)
			duty = '0;
		else if (o > dbpi_pkg::DUTY_MAX)
			duty = dbpi_pkg::DUTY_W'(dbpi_pkg::DUTY_MAX);
		else
			duty = o[dbpi_pkg::DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (ctl.clear) begin
			integ_q <= '0;
		end else if (ctl.step) begin
			integ_q <= integ_next;
		end
	end

endmodule

FILE: rtl/dbpi_checker.sv
// Port-level checker for the dead-band PI light controller, with its bind.
module dbpi_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_ready,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic [dbpi_pkg::DUTY_W-1:0]   duty,
	input logic                          active
);

	a_inactive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !active |-> duty == '0)
		else $error("inactive word carries nonzero duty");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> duty <= dbpi_pkg::DUTY_W'(dbpi_pkg::DUTY_MAX))
		else $error("duty above limit");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid && !result_ready)
		else $error("input stalled without output backpressure");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(duty) && $stable(active))
		else $error("stalled result word changed");

endmodule

bind deadband_pi_light_controller dbpi_checker u_dbpi_checker (.*);
